@@ hdl/ata_pio_pkg.sv @@
package ata_pio_pkg;

   localparam int MAX_RES = 7;
   localparam int CNT_W   = 3;

   localparam logic [7:0] ST_BSY  = 8'h80;
   localparam logic [7:0] ST_DRDY = 8'h40;
   localparam logic [7:0] ST_DRQ  = 8'h08;
   localparam logic [7:0] ST_ERR  = 8'h01;

   localparam logic [7:0] DEV_HEAD_BASE = 8'hE0;
   localparam logic [3:0] LBA_TOP_MASK  = 4'hF;
   localparam logic [7:0] CMD_READ      = 8'h20;
   localparam logic [7:0] CMD_WRITE     = 8'h30;
   localparam logic [7:0] CMD_FLUSH     = 8'hE7;

   localparam logic [15:0] TIMEOUT_RESET = 16'd10000;

   localparam logic [1:0] FUNC_START_RD = 2'd0;
   localparam logic [1:0] FUNC_START_WR = 2'd1;
   localparam logic [1:0] FUNC_REPLY    = 2'd2;
   localparam logic [1:0] FUNC_HOST_WORD = 2'd3;

   localparam logic [2:0] REG_DATA     = 3'd0;
   localparam logic [2:0] REG_FEATURES = 3'd1;
   localparam logic [2:0] REG_COUNT    = 3'd2;
   localparam logic [2:0] REG_LBA_LO   = 3'd3;
   localparam logic [2:0] REG_LBA_MID  = 3'd4;
   localparam logic [2:0] REG_LBA_HI   = 3'd5;
   localparam logic [2:0] REG_DEVICE   = 3'd6;
   localparam logic [2:0] REG_STATUS   = 3'd7;

   localparam logic [1:0] CODE_OK      = 2'd0;
   localparam logic [1:0] CODE_TIMEOUT = 2'd1;
   localparam logic [1:0] CODE_DEV_ERR = 2'd2;

   localparam logic [3:0] PH_IDLE  = 4'd0;
   localparam logic [3:0] PH_BSY   = 4'd1;
   localparam logic [3:0] PH_DRDY  = 4'd2;
   localparam logic [3:0] PH_DRQ   = 4'd3;
   localparam logic [3:0] PH_RDATA = 4'd4;
   localparam logic [3:0] PH_RERR  = 4'd5;
   localparam logic [3:0] PH_WDATA = 4'd6;
   localparam logic [3:0] PH_FLUSH = 4'd7;

   typedef struct packed {
      logic        bus_valid;
      logic        bus_is_write;
      logic [2:0]  bus_reg;
      logic [15:0] bus_value;
      logic        word_valid;
      logic [15:0] word_out;
      logic        need_word;
      logic        done_res;
      logic [1:0]  status_code;
   } result_type;

   typedef struct packed {
      logic [CNT_W-1:0]                 count;
      result_type [MAX_RES-1:0]         res;
   } plan_type;

   function automatic result_type mk_write(input logic [2:0] r, input logic [15:0] v);
      result_type t;
      t = '0;
      t.bus_valid    = 1'b1;
      t.bus_is_write = 1'b1;
      t.bus_reg      = r;
      t.bus_value    = v;
      return t;
   endfunction

   function automatic result_type mk_read(input logic [2:0] r);
      result_type t;
      t = '0;
      t.bus_valid = 1'b1;
      t.bus_reg   = r;
      return t;
   endfunction

   function automatic result_type mk_done(input logic [1:0] code);
      result_type t;
      t = '0;
      t.done_res    = 1'b1;
      t.status_code = code;
      return t;
   endfunction

   function automatic result_type mk_word(input logic [15:0] w);
      result_type t;
      t = '0;
      t.word_valid = 1'b1;
      t.word_out   = w;
      return t;
   endfunction

   function automatic result_type mk_need();
      result_type t;
      t = '0;
      t.need_word = 1'b1;
      return t;
   endfunction

endpackage

@@ hdl/ata_pio_core.sv @@
module ata_pio_core #(
   parameter int SECTOR_WORDS = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  logic [1:0]            func,
   input  logic [27:0]           lba,
   input  logic [15:0]           data,
   input  logic [15:0]           timeout_limit,
   output ata_pio_pkg::plan_type plan
);

   localparam int WC_W = $clog2(SECTOR_WORDS + 1);

   logic [3:0]      phase_ff, phase_in;
   logic            is_write_ff, is_write_in;
   logic [27:0]     addr_ff, addr_in;
   logic [15:0]     poll_ff, poll_in;
   logic [WC_W-1:0] wc_ff, wc_in;

   logic [15:0]     poll_load;
   logic [15:0]     poll_dec;
   logic [WC_W-1:0] wc_inc;
   logic            more_words;

   assign poll_load  = (timeout_limit == 16'd0) ? 16'd1 : timeout_limit;
   assign poll_dec   = poll_ff - 16'd1;
   assign wc_inc     = wc_ff + WC_W'(1);
   assign more_words = wc_inc < WC_W'(SECTOR_WORDS);

   always_comb begin
      plan        = '0;
      phase_in    = phase_ff;
      is_write_in = is_write_ff;
      addr_in     = addr_ff;
      poll_in     = poll_ff;
      wc_in       = wc_ff;
      unique case (func)
         ata_pio_pkg::FUNC_START_RD, ata_pio_pkg::FUNC_START_WR: begin
            if (phase_ff == ata_pio_pkg::PH_IDLE) begin
               is_write_in = func[0];
               addr_in     = lba;
               wc_in       = '0;
               poll_in     = poll_load;
               phase_in    = ata_pio_pkg::PH_BSY;
               plan.res[0] = ata_pio_pkg::mk_read(ata_pio_pkg::REG_STATUS);
               plan.count  = 3'd1;
            end
         end
         ata_pio_pkg::FUNC_REPLY: begin
            unique case (phase_ff)
               ata_pio_pkg::PH_BSY, ata_pio_pkg::PH_DRDY, ata_pio_pkg::PH_FLUSH: begin
                  if ((phase_ff != ata_pio_pkg::PH_DRDY && (data[7:0] & ata_pio_pkg::ST_BSY) == '0)
                      || (phase_ff == ata_pio_pkg::PH_DRDY
                          && (data[7:0] & ata_pio_pkg::ST_DRDY) != '0)) begin
                     poll_in = poll_load;
                     if (phase_ff == ata_pio_pkg::PH_BSY) begin
                        plan.res[0] = ata_pio_pkg::mk_write(ata_pio_pkg::REG_DEVICE,
                           {8'h00, ata_pio_pkg::DEV_HEAD_BASE
                                   | {4'h0, addr_ff[27:24] & ata_pio_pkg::LBA_TOP_MASK}});
                        plan.res[1] = ata_pio_pkg::mk_read(ata_pio_pkg::REG_STATUS);
                        plan.count  = 3'd2;
                        phase_in    = ata_pio_pkg::PH_DRDY;
                     end else if (phase_ff == ata_pio_pkg::PH_DRDY) begin
                        plan.res[0] = ata_pio_pkg::mk_write(ata_pio_pkg::REG_FEATURES, 16'h0000);
                        plan.res[1] = ata_pio_pkg::mk_write(ata_pio_pkg::REG_COUNT, 16'h0001);
                        plan.res[2] = ata_pio_pkg::mk_write(ata_pio_pkg::REG_LBA_LO,
                                                            {8'h00, addr_ff[7:0]});
                        plan.res[3] = ata_pio_pkg::mk_write(ata_pio_pkg::REG_LBA_MID,
                                                            {8'h00, addr_ff[15:8]});
                        plan.res[4] = ata_pio_pkg::mk_write(ata_pio_pkg::REG_LBA_HI,
                                                            {8'h00, addr_ff[23:16]});
                        plan.res[5] = ata_pio_pkg::mk_write(ata_pio_pkg::REG_STATUS,
                           {8'h00, is_write_ff ? ata_pio_pkg::CMD_WRITE
                                               : ata_pio_pkg::CMD_READ});
                        plan.res[6] = ata_pio_pkg::mk_read(ata_pio_pkg::REG_STATUS);
                        plan.count  = 3'd7;
                        phase_in    = ata_pio_pkg::PH_DRQ;
                     end else begin
                        plan.res[0] = ata_pio_pkg::mk_done(ata_pio_pkg::CODE_OK);
                        plan.count  = 3'd1;
                        phase_in    = ata_pio_pkg::PH_IDLE;
                     end
                  end else begin
                     poll_in    = poll_dec;
                     plan.count = 3'd1;
                     if (poll_dec == 16'd0) begin
                        plan.res[0] = ata_pio_pkg::mk_done(ata_pio_pkg::CODE_TIMEOUT);
                        phase_in    = ata_pio_pkg::PH_IDLE;
                     end else begin
                        plan.res[0] = ata_pio_pkg::mk_read(ata_pio_pkg::REG_STATUS);
                     end
                  end
               end
               ata_pio_pkg::PH_DRQ: begin
                  plan.count = 3'd1;
                  if ((data[7:0] & ata_pio_pkg::ST_DRQ) != '0) begin
                     wc_in = '0;
                     if (is_write_ff) begin
                        phase_in    = ata_pio_pkg::PH_WDATA;
                        plan.res[0] = ata_pio_pkg::mk_need();
                     end else begin
                        phase_in    = ata_pio_pkg::PH_RDATA;
                        plan.res[0] = ata_pio_pkg::mk_read(ata_pio_pkg::REG_DATA);
                     end
                  end else if ((data[7:0] & ata_pio_pkg::ST_ERR) != '0) begin
                     plan.res[0] = ata_pio_pkg::mk_done(ata_pio_pkg::CODE_DEV_ERR);
                     phase_in    = ata_pio_pkg::PH_IDLE;
                  end else begin
                     poll_in = poll_dec;
                     if (poll_dec == 16'd0) begin
                        plan.res[0] = ata_pio_pkg::mk_done(ata_pio_pkg::CODE_TIMEOUT);
                        phase_in    = ata_pio_pkg::PH_IDLE;
                     end else begin
                        plan.res[0] = ata_pio_pkg::mk_read(ata_pio_pkg::REG_STATUS);
                     end
                  end
               end
               ata_pio_pkg::PH_RDATA: begin
                  plan.res[0] = ata_pio_pkg::mk_word(data);
                  plan.count  = 3'd2;
                  wc_in       = wc_inc;
                  if (more_words) begin
                     plan.res[1] = ata_pio_pkg::mk_read(ata_pio_pkg::REG_DATA);
                  end else begin
                     plan.res[1] = ata_pio_pkg::mk_read(ata_pio_pkg::REG_STATUS);
                     phase_in    = ata_pio_pkg::PH_RERR;
                  end
               end
               ata_pio_pkg::PH_RERR: begin
                  plan.res[0] = ata_pio_pkg::mk_done(((data[7:0] & ata_pio_pkg::ST_ERR) != '0)
                                   ? ata_pio_pkg::CODE_DEV_ERR : ata_pio_pkg::CODE_OK);
                  plan.count  = 3'd1;
                  phase_in    = ata_pio_pkg::PH_IDLE;
               end
               default: begin
               end
            endcase
         end
         ata_pio_pkg::FUNC_HOST_WORD: begin
            if (phase_ff == ata_pio_pkg::PH_WDATA) begin
               plan.res[0] = ata_pio_pkg::mk_write(ata_pio_pkg::REG_DATA, data);
               wc_in       = wc_inc;
               if (more_words) begin
                  plan.res[1] = ata_pio_pkg::mk_need();
                  plan.count  = 3'd2;
               end else begin
                  plan.res[1] = ata_pio_pkg::mk_write(ata_pio_pkg::REG_STATUS,
                                                      {8'h00, ata_pio_pkg::CMD_FLUSH});
                  plan.res[2] = ata_pio_pkg::mk_read(ata_pio_pkg::REG_STATUS);
                  plan.count  = 3'd3;
                  poll_in     = poll_load;
                  phase_in    = ata_pio_pkg::PH_FLUSH;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= ata_pio_pkg::PH_IDLE;
         is_write_ff <= 1'b0;
         addr_ff     <= '0;
         poll_ff     <= '0;
         wc_ff       <= '0;
      end else if (fire) begin
         phase_ff    <= phase_in;
         is_write_ff <= is_write_in;
         addr_ff     <= addr_in;
         poll_ff     <= poll_in;
         wc_ff       <= wc_in;
      end
   end

endmodule

@@ hdl/ata_pio_outbuf.sv @@
module ata_pio_outbuf (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  ata_pio_pkg::plan_type   plan,
   output logic                    free,
   output logic                    out_valid,
   output logic                    out_last,
   output ata_pio_pkg::result_type out_res,
   input  logic                    out_ready
);

   ata_pio_pkg::result_type [ata_pio_pkg::MAX_RES-1:0] res_ff, res_in;
   logic [ata_pio_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic take;

   assign out_valid = cnt_ff != '0;
   assign out_last  = cnt_ff == ata_pio_pkg::CNT_W'(1);
   assign out_res   = res_ff[0];
   assign take      = out_valid && out_ready;
   assign free      = !out_valid || (out_last && out_ready);

   always_comb begin
      res_in = res_ff;
      cnt_in = cnt_ff;
      if (load) begin
         res_in = plan.res;
         cnt_in = plan.count;
      end else if (take) begin
         for (int i = 0; i < ata_pio_pkg::MAX_RES - 1; i++) begin
            res_in[i] = res_ff[i+1];
         end
         cnt_in = cnt_ff - ata_pio_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

@@ hdl/ata_pio_sector_sequencer_unit.sv @@
// ata pio sector sequencer: host side of one lba28 sector pio transfer
// req channel: one transaction per start, drive register reply or host word;
//   req_tuser carries the function, req_tdata the sector address and data
// rsp channel: the bus accesses, host words, word requests and done report
//   caused by one req transaction, tlast set on the final one
// csr port: single write-only poll limit register, reset value 10000
// path: a req transaction is held in the input register, then its
//   responses are loaded into the result buffer once it is free, and the
//   first of them is offered from there
// throughput: one req transaction per cycle while each yields one response
//   and rsp_tready is high; a transaction with n responses (at most 7, the
//   task file write burst) holds the result buffer until its final response
//   leaves, and the next one is taken as that final response leaves
// reset clears the phase to idle, empties both registers and reloads the
//   poll limit; no clearing pass is needed
// when rsp_tready is low the buffered responses hold and one further req
//   transaction waits in the input register before req_tready drops
module ata_pio_sector_sequencer_unit #(
   parameter int SECTOR_WORDS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // lba[27:0], data[43:28], zero pad
   input  logic [1:0]  req_tuser,  // func[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // bus_valid, bus_is_write, bus_reg[2:0], bus_value[15:0],
                                   // word_valid, word_out[15:0], need_word, done_res,
                                   // status_code[1:0], zero pad
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic        in_valid_ff, in_valid_in;
   logic [1:0]  func_ff;
   logic [27:0] lba_ff;
   logic [15:0] data_ff;
   logic [15:0] limit_ff;
   logic        load;
   logic        free;
   ata_pio_pkg::plan_type   plan;
   ata_pio_pkg::result_type res;

   assign load        = in_valid_ff && free;
   assign req_tready  = !in_valid_ff || load;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !load);

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         func_ff <= req_tuser;
         lba_ff  <= req_tdata[27:0];
         data_ff <= req_tdata[43:28];
      end
      if (reset) begin
         in_valid_ff <= 1'b0;
         limit_ff    <= ata_pio_pkg::TIMEOUT_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
      end
   end

   ata_pio_core #(
      .SECTOR_WORDS(SECTOR_WORDS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .fire         (load),
      .func         (func_ff),
      .lba          (lba_ff),
      .data         (data_ff),
      .timeout_limit(limit_ff),
      .plan         (plan)
   );

   ata_pio_outbuf u_outbuf (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .plan     (plan),
      .free     (free),
      .out_valid(rsp_tvalid),
      .out_last (rsp_tlast),
      .out_res  (res),
      .out_ready(rsp_tready)
   );

   assign rsp_tdata = {6'd0, res.status_code, res.done_res, res.need_word, res.word_out,
                       res.word_valid, res.bus_value, res.bus_reg, res.bus_is_write,
                       res.bus_valid};

endmodule

@@ hdl/ata_pio_checker.sv @@
module ata_pio_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic        rsp_tlast
);

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled response changed");

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response offered after reset");

   // the rest of a multi-response transaction follows with no gap
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("gap inside a response burst");

   // done report is the final response and carries no bus access
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[39] |-> rsp_tlast && !rsp_tdata[0])
      else $error("malformed done response");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[41:40] != 2'd0 |-> rsp_tdata[39] && rsp_tdata[41:40] != 2'd3)
      else $error("status code without done");

endmodule

bind ata_pio_sector_sequencer_unit ata_pio_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tlast (rsp_tlast)
);
